// ===== rtl/core/qsa_pkg.sv =====
// ----------------------------------------------------------------------------
// qsa_pkg
// Shared types, field widths and codes for the quota slot allocator.
// ----------------------------------------------------------------------------
package qsa_pkg;

  localparam int unsigned ReqW    = 2;
  localparam int unsigned OwnerW  = 16;
  localparam int unsigned IndexW  = 6;
  localparam int unsigned StatusW = 2;
  localparam int unsigned AddrW   = 33;
  localparam int unsigned FreeW   = 7;
  localparam int unsigned RefW    = 32;
  localparam int unsigned CapW    = 7;
  localparam int unsigned BaseW   = 32;
  localparam int unsigned BytesW  = 17;
  localparam int unsigned PaddrW  = 4;
  localparam int unsigned PdataW  = 32;

  typedef enum logic [ReqW-1:0] {
    ReqClaim   = 2'd0,
    ReqRelease = 2'd1,
    ReqClose   = 2'd2
  } qsa_req_e;

  typedef enum logic [StatusW-1:0] {
    StatDone       = 2'd0,
    StatRefused    = 2'd1,
    StatClosed     = 2'd2,
    StatNotClaimed = 2'd3
  } qsa_status_e;

  typedef enum logic [1:0] {
    RegOwnerCap  = 2'd0,
    RegSlotBase  = 2'd1,
    RegSlotBytes = 2'd2
  } qsa_reg_e;

  typedef struct packed {
    logic        accept;
    logic        set_status;
    qsa_status_e status;
    logic        refuse;
    logic        release_slot;
    logic        close_pool;
    logic        scan_start;
    logic        scan;
    logic        pop;
    logic        grant;
    logic        out_load;
  } qsa_cmd_t;

  typedef struct packed {
    logic [ReqW-1:0] req;
    logic            closed;
    logic            stack_empty;
    logic            cap_on;
    logic            rel_ok;
    logic            scan_done;
    logic            at_cap;
  } qsa_sts_t;

endpackage

// ===== rtl/core/qsa_ctrl.sv =====
// ----------------------------------------------------------------------------
// qsa_ctrl
// Request sequencer: decodes each word, runs the holder scan, pop and grant
// steps and owns the output valid.
// ----------------------------------------------------------------------------
module qsa_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  input  qsa_pkg::qsa_sts_t sts_i,
  output qsa_pkg::qsa_cmd_t cmd_o
);

  typedef enum logic [6:0] {
    StIdle   = 7'b0000001,
    StDecide = 7'b0000010,
    StScan   = 7'b0000100,
    StCapChk = 7'b0001000,
    StPop    = 7'b0010000,
    StGrant  = 7'b0100000,
    StEmit   = 7'b1000000
  } qsa_state_e;

  qsa_state_e state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;

  assign out_free    = !out_valid_q || !out_stall_i;
  assign in_stall_o  = (state_q != StIdle);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.status = qsa_pkg::StatDone;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d = StDecide;
        end
      end
      StDecide: begin
        state_d = StEmit;
        case (sts_i.req)
          qsa_pkg::ReqClaim: begin
            if (sts_i.closed) begin
              cmd_o.set_status = 1'b1;
              cmd_o.status     = qsa_pkg::StatClosed;
            end else if (sts_i.stack_empty) begin
              cmd_o.refuse = 1'b1;
            end else if (sts_i.cap_on) begin
              cmd_o.scan_start = 1'b1;
              state_d = StScan;
            end else begin
              state_d = StPop;
            end
          end
          qsa_pkg::ReqRelease: begin
            if (sts_i.rel_ok) begin
              cmd_o.release_slot = 1'b1;
            end else begin
              cmd_o.set_status = 1'b1;
              cmd_o.status     = qsa_pkg::StatNotClaimed;
            end
          end
          qsa_pkg::ReqClose: begin
            cmd_o.close_pool = 1'b1;
          end
          default: ;
        endcase
      end
      StScan: begin
        cmd_o.scan = 1'b1;
        if (sts_i.scan_done) begin
          state_d = StCapChk;
        end
      end
      StCapChk: begin
        if (sts_i.at_cap) begin
          cmd_o.refuse = 1'b1;
          state_d = StEmit;
        end else begin
          state_d = StPop;
        end
      end
      StPop: begin
        cmd_o.pop = 1'b1;
        state_d = StGrant;
      end
      StGrant: begin
        cmd_o.grant = 1'b1;
        state_d = StEmit;
      end
      StEmit: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> (!out_valid_q || !out_stall_i))
    else $error("result loaded over an untaken word");

  a_accept_decides: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (state_q == StDecide))
    else $error("accepted word not decoded next cycle");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> out_valid_o)
    else $error("stalled result word dropped");

endmodule

// ===== rtl/core/qsa_dp.sv =====
// ----------------------------------------------------------------------------
// qsa_dp
// Allocator datapath: free stack and holder memories, busy bits, holder
// scan counter, refusal counter and the output register.
// ----------------------------------------------------------------------------
module qsa_dp #(
  parameter int unsigned NUM_SLOTS  = 64,
  parameter int unsigned OWNER_BITS = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  qsa_pkg::qsa_cmd_t                cmd_i,
  output qsa_pkg::qsa_sts_t                sts_o,
  input  logic [qsa_pkg::ReqW-1:0]         req_type_i,
  input  logic [qsa_pkg::OwnerW-1:0]       owner_i,
  input  logic [qsa_pkg::IndexW-1:0]       slot_index_i,
  input  logic [qsa_pkg::CapW-1:0]         owner_cap_i,
  input  logic [qsa_pkg::BaseW-1:0]        slot_base_i,
  input  logic [qsa_pkg::BytesW-1:0]       slot_bytes_i,
  output logic [qsa_pkg::StatusW-1:0]      status_o,
  output logic [qsa_pkg::IndexW-1:0]       granted_index_o,
  output logic [qsa_pkg::AddrW-1:0]        granted_address_o,
  output logic [qsa_pkg::FreeW-1:0]        free_slots_o,
  output logic [qsa_pkg::RefW-1:0]         refused_total_o
);

  localparam int unsigned SlotW   = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int unsigned CntW    = $clog2(NUM_SLOTS + 1);
  localparam int unsigned HolderW = (OWNER_BITS < qsa_pkg::OwnerW) ? OWNER_BITS
                                                                   : qsa_pkg::OwnerW;
  localparam int unsigned ProdW   = SlotW + qsa_pkg::BytesW;
  localparam int unsigned CmpW    = (CntW > qsa_pkg::CapW) ? CntW : qsa_pkg::CapW;

  logic [qsa_pkg::ReqW-1:0]   req_q;
  logic [HolderW-1:0]         who_q;
  logic [qsa_pkg::IndexW-1:0] idx_q;

  qsa_pkg::qsa_status_e       res_status_q;
  logic                       res_grant_q;
  logic [SlotW-1:0]           res_idx_q;
  logic [ProdW-1:0]           prod_q;

  logic [CntW-1:0]            free_top_q;
  logic                       closed_q;
  logic [qsa_pkg::RefW-1:0]   refusals_q;
  logic [NUM_SLOTS-1:0]       busy_q;
  logic [NUM_SLOTS-1:0]       stack_vld_q;

  logic [SlotW-1:0]           stack_mem [NUM_SLOTS];
  logic [HolderW-1:0]         holder_mem [NUM_SLOTS];

  logic [SlotW-1:0]           stk_rd_q;
  logic [SlotW-1:0]           stk_rd_addr_q;
  logic                       stk_rd_vld_q;

  logic [CntW-1:0]            scan_ptr_q;
  logic                       cmp_v_q;
  logic                       busy_rd_q;
  logic [HolderW-1:0]         holder_rd_q;
  logic [CntW-1:0]            held_q;

  qsa_pkg::qsa_status_e       out_status_q;
  logic [qsa_pkg::IndexW-1:0] out_idx_q;
  logic [qsa_pkg::AddrW-1:0]  out_addr_q;
  logic [qsa_pkg::FreeW-1:0]  out_free_q;
  logic [qsa_pkg::RefW-1:0]   out_ref_q;

  logic             idx_ok;
  logic [SlotW-1:0] idx_sel;
  logic [CntW-1:0]  free_top_m1;
  logic [SlotW-1:0] push_addr;
  logic [SlotW-1:0] pop_addr;
  logic [SlotW-1:0] ptr_idx;
  logic             ptr_end;
  logic             push_ok;
  logic [SlotW-1:0] slot_sel;
  logic             held_hit;

  assign idx_ok      = (int'(idx_q) < NUM_SLOTS);
  assign idx_sel     = SlotW'(idx_q);
  assign free_top_m1 = free_top_q - CntW'(1);
  assign push_addr   = free_top_q[SlotW-1:0];
  assign pop_addr    = free_top_m1[SlotW-1:0];
  assign ptr_idx     = scan_ptr_q[SlotW-1:0];
  assign ptr_end     = (scan_ptr_q == CntW'(NUM_SLOTS));
  assign push_ok     = (int'(free_top_q) < NUM_SLOTS);
  assign slot_sel    = stk_rd_vld_q ? stk_rd_q
                                    : (SlotW'(NUM_SLOTS - 1) - stk_rd_addr_q);
  assign held_hit    = cmp_v_q && busy_rd_q && (holder_rd_q == who_q);

  assign sts_o.req         = req_q;
  assign sts_o.closed      = closed_q;
  assign sts_o.stack_empty = (free_top_q == '0);
  assign sts_o.cap_on      = (owner_cap_i != '0);
  assign sts_o.rel_ok      = idx_ok && busy_q[idx_sel];
  assign sts_o.scan_done   = ptr_end && !cmp_v_q;
  assign sts_o.at_cap      = (CmpW'(held_q) >= CmpW'(owner_cap_i));

  // request capture and result staging
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      req_q        <= req_type_i;
      who_q        <= owner_i[HolderW-1:0];
      idx_q        <= slot_index_i;
      res_status_q <= qsa_pkg::StatDone;
      res_grant_q  <= 1'b0;
      res_idx_q    <= '0;
      prod_q       <= '0;
    end
    if (cmd_i.set_status) begin
      res_status_q <= cmd_i.status;
    end
    if (cmd_i.refuse) begin
      res_status_q <= qsa_pkg::StatRefused;
    end
    if (cmd_i.grant) begin
      res_grant_q <= 1'b1;
      res_idx_q   <= slot_sel;
      prod_q      <= ProdW'(slot_sel) * ProdW'(slot_bytes_i);
    end
  end

  // pool state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      free_top_q   <= CntW'(NUM_SLOTS);
      closed_q     <= 1'b0;
      refusals_q   <= '0;
      busy_q       <= '0;
      stack_vld_q  <= '0;
      stk_rd_vld_q <= 1'b0;
      scan_ptr_q   <= '0;
      cmp_v_q      <= 1'b0;
      held_q       <= '0;
    end else begin
      if (cmd_i.refuse && (refusals_q != '1)) begin
        refusals_q <= refusals_q + qsa_pkg::RefW'(1);
      end
      if (cmd_i.close_pool) begin
        closed_q <= 1'b1;
      end
      if (cmd_i.release_slot) begin
        busy_q[idx_sel] <= 1'b0;
        if (push_ok) begin
          stack_vld_q[push_addr] <= 1'b1;
          free_top_q <= free_top_q + CntW'(1);
        end
      end
      if (cmd_i.pop) begin
        stk_rd_vld_q <= stack_vld_q[pop_addr];
        free_top_q   <= free_top_m1;
      end
      if (cmd_i.grant) begin
        busy_q[slot_sel] <= 1'b1;
      end
      if (cmd_i.scan_start) begin
        scan_ptr_q <= '0;
        cmp_v_q    <= 1'b0;
        held_q     <= '0;
      end
      if (cmd_i.scan) begin
        cmp_v_q <= !ptr_end;
        if (!ptr_end) begin
          scan_ptr_q <= scan_ptr_q + CntW'(1);
        end
        if (held_hit) begin
          held_q <= held_q + CntW'(1);
        end
      end
    end
  end

  // free stack memory
  always_ff @(posedge clk_i) begin
    if (cmd_i.release_slot && push_ok) begin
      stack_mem[push_addr] <= idx_sel;
    end
    if (cmd_i.pop) begin
      stk_rd_q      <= stack_mem[pop_addr];
      stk_rd_addr_q <= pop_addr;
    end
  end

  // holder memory
  always_ff @(posedge clk_i) begin
    if (cmd_i.grant) begin
      holder_mem[slot_sel] <= who_q;
    end
    if (cmd_i.scan && !ptr_end) begin
      holder_rd_q <= holder_mem[ptr_idx];
      busy_rd_q   <= busy_q[ptr_idx];
    end
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_status_q <= res_status_q;
      out_idx_q    <= qsa_pkg::IndexW'(res_idx_q);
      out_addr_q   <= res_grant_q ? (qsa_pkg::AddrW'(slot_base_i) + qsa_pkg::AddrW'(prod_q))
                                  : '0;
      out_free_q   <= qsa_pkg::FreeW'(free_top_q);
      out_ref_q    <= refusals_q;
    end
  end

  assign status_o          = out_status_q;
  assign granted_index_o   = out_idx_q;
  assign granted_address_o = out_addr_q;
  assign free_slots_o      = out_free_q;
  assign refused_total_o   = out_ref_q;

  a_slot_conservation: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cmd_i.grant |-> ($countones(busy_q) + int'(free_top_q) == NUM_SLOTS))
    else $error("busy and free slot counts disagree");

  a_grant_free_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.grant |-> !busy_q[slot_sel])
    else $error("granted slot already busy");

  a_refusals_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> (refusals_q >= $past(refusals_q)))
    else $error("refusal count went down");

endmodule

// ===== rtl/core/quota_slot_allocator.sv =====
// ----------------------------------------------------------------------------
// quota_slot_allocator
// Fixed-size slot allocator with a LIFO free stack and per-owner quota.
// ----------------------------------------------------------------------------
// One request word is handled at a time. A release, close or claim rejected at
// decode passes straight to the emit state; an uncapped claim first does the
// free stack read, then grant and address multiply. With owner_cap set, a
// claim also walks the holder memory one entry per cycle through its single
// read port to count the owner's slots and then checks the cap. The next word
// is accepted once the result sits in the output register.
module quota_slot_allocator #(
  parameter int unsigned NUM_SLOTS  = 64,
  parameter int unsigned OWNER_BITS = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [qsa_pkg::PaddrW-1:0]     paddr,
  input  logic [qsa_pkg::PdataW-1:0]     pwdata,
  output logic [qsa_pkg::PdataW-1:0]     prdata,
  output logic                           pready,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [qsa_pkg::ReqW-1:0]       req_type_i,
  input  logic [qsa_pkg::OwnerW-1:0]     owner_i,
  input  logic [qsa_pkg::IndexW-1:0]     slot_index_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [qsa_pkg::StatusW-1:0]    status_o,
  output logic [qsa_pkg::IndexW-1:0]     granted_index_o,
  output logic [qsa_pkg::AddrW-1:0]      granted_address_o,
  output logic [qsa_pkg::FreeW-1:0]      free_slots_o,
  output logic [qsa_pkg::RefW-1:0]       refused_total_o
);

  logic [qsa_pkg::CapW-1:0]   owner_cap_q;
  logic [qsa_pkg::BaseW-1:0]  slot_base_q;
  logic [qsa_pkg::BytesW-1:0] slot_bytes_q;
  logic                       cfg_wr;

  qsa_pkg::qsa_cmd_t cmd;
  qsa_pkg::qsa_sts_t sts;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      owner_cap_q  <= '0;
      slot_base_q  <= '0;
      slot_bytes_q <= qsa_pkg::BytesW'(1);
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        qsa_pkg::RegOwnerCap:  owner_cap_q  <= pwdata[qsa_pkg::CapW-1:0];
        qsa_pkg::RegSlotBase:  slot_base_q  <= pwdata[qsa_pkg::BaseW-1:0];
        qsa_pkg::RegSlotBytes: slot_bytes_q <= pwdata[qsa_pkg::BytesW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      qsa_pkg::RegOwnerCap:  prdata = qsa_pkg::PdataW'(owner_cap_q);
      qsa_pkg::RegSlotBase:  prdata = qsa_pkg::PdataW'(slot_base_q);
      qsa_pkg::RegSlotBytes: prdata = qsa_pkg::PdataW'(slot_bytes_q);
      default:               prdata = '0;
    endcase
  end

  qsa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  qsa_dp #(
    .NUM_SLOTS  (NUM_SLOTS),
    .OWNER_BITS (OWNER_BITS)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .req_type_i        (req_type_i),
    .owner_i           (owner_i),
    .slot_index_i      (slot_index_i),
    .owner_cap_i       (owner_cap_q),
    .slot_base_i       (slot_base_q),
    .slot_bytes_i      (slot_bytes_q),
    .status_o          (status_o),
    .granted_index_o   (granted_index_o),
    .granted_address_o (granted_address_o),
    .free_slots_o      (free_slots_o),
    .refused_total_o   (refused_total_o)
  );

endmodule
